/* hw/rtl/kwb_pkg.sv */
// Shared types, constants and fixed-point helpers for the K-weighting filter.
// Used by kwb_mac and k_weighting_biquad_cascade_core; no dependencies.
package kwb_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHAN_W   = 3;
  localparam int IDX_W    = (CH_AW > CHAN_W) ? CH_AW : CHAN_W;
  localparam int SAMP_W   = 24;
  localparam int COEF_W   = 32;
  localparam int ACC_W    = 64;
  localparam int NUM_REGS = 7;

  typedef enum logic [2:0] {
    REG_SHELF_B0 = 3'd0,
    REG_SHELF_B1 = 3'd1,
    REG_SHELF_B2 = 3'd2,
    REG_SHELF_A1 = 3'd3,
    REG_SHELF_A2 = 3'd4,
    REG_HP_A1    = 3'd5,
    REG_HP_A2    = 3'd6
  } reg_idx_t;

  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_REGS] = '{
    32'sd412081942, -32'sd722546695, 32'sd321691120, -32'sd453832899,
    32'sd196623811, -32'sd534199296, 32'sd265770496
  };

  typedef struct packed {
    logic signed [SAMP_W-1:0] x1;
    logic signed [SAMP_W-1:0] x2;
    logic signed [COEF_W-1:0] s1;
    logic signed [COEF_W-1:0] s2;
    logic signed [COEF_W-1:0] h1;
    logic signed [COEF_W-1:0] h2;
  } hist_row_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_sub;
    logic acc_ld;
  } mac_ctrl_t;

  // Round Q31-scale sum to Q26.6 and saturate to 32 bits.
  function automatic logic signed [COEF_W-1:0] to_q6(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [38:0]      q;
    t = acc + 64'sd16777216;
    q = 39'(t >>> 25);
    if (q > 39'sd2147483647) return 32'sh7fffffff;
    if (q < -39'sd2147483648) return 32'sh80000000;
    return 32'(q);
  endfunction

  // Round Q26.6 to integer and saturate to 24 bits.
  function automatic logic signed [SAMP_W-1:0] out_round(input logic signed [COEF_W-1:0] y);
    logic signed [COEF_W:0] t;
    logic signed [26:0]     q;
    t = $signed({y[COEF_W-1], y}) + 33'sd32;
    q = 27'(t >>> 6);
    if (q > 27'sd8388607) return 24'sh7fffff;
    if (q < -27'sd8388608) return 24'sh800000;
    return 24'(q);
  endfunction

endpackage

/* hw/rtl/kwb_mac.sv */
// Shared multiply-accumulate unit: registered 32x32 product, 64-bit accumulator.
// Depends on kwb_pkg.
module kwb_mac (
  input  logic                                  clk,
  input  kwb_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [kwb_pkg::COEF_W-1:0]     coef,
  input  logic signed [kwb_pkg::COEF_W-1:0]     opnd,
  input  logic signed [kwb_pkg::ACC_W-1:0]      ld_val,
  output logic signed [kwb_pkg::ACC_W-1:0]      acc
);

  logic signed [kwb_pkg::ACC_W-1:0] prod_r;
  logic signed [kwb_pkg::ACC_W-1:0] acc_r;
  logic signed [kwb_pkg::ACC_W-1:0] acc_nxt;
  logic signed [kwb_pkg::ACC_W-1:0] term;

  assign term = prod_r >>> 3;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.acc_ld) begin
      acc_nxt = ld_val;
    end else if (ctrl.acc_en) begin
      acc_nxt = ctrl.acc_sub ? (acc_r - term) : (acc_r + term);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= kwb_pkg::ACC_W'(coef) * kwb_pkg::ACC_W'(opnd);
    end
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

/* hw/rtl/k_weighting_biquad_cascade_core.sv */
// Top level of the multichannel K-weighting prefilter (shelf + high-pass biquads).
// Depends on kwb_pkg and kwb_mac.
//
// Usage:
//   Input channel in_valid/in_ready carries a channel number and a signed 24-bit
//   sample; output channel out_valid/out_ready returns the channel and the
//   K-weighted, saturated sample, one transaction out per transaction in, in order.
//   Coefficients are written through cfg_we/cfg_idx/cfg_wdata; the user must write them only while idle (not enforced).
// Timing:
//   After acceptance, seven products run through the single shared multiplier one
//   per cycle, with round, numerator and write-back steps. in_ready returns the
//   cycle after the result is loaded, so a new transaction is accepted only once
//   the previous result has been loaded into the output register.
//   A channel number at or above the channel count skips the filter and returns zero.
// Reset:
//   Coefficients return to their 48 kHz values and every channel history reads
//   as zero (per-channel valid bits are cleared).
// Stall:
//   A waiting result sits in the output register while the next transaction is
//   processed; a finished transaction holds in write-back until the register frees.
module k_weighting_biquad_cascade_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [kwb_pkg::CHAN_W-1:0]          in_chan,
  input  logic signed [kwb_pkg::SAMP_W-1:0]   in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [kwb_pkg::CHAN_W-1:0]          out_chan_out,
  output logic signed [kwb_pkg::SAMP_W-1:0]   out_sample_out,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_idx,
  input  logic [kwb_pkg::COEF_W-1:0]          cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHELF = 7'b0000010,
    S_SQ    = 7'b0000100,
    S_HPI   = 7'b0001000,
    S_HP    = 7'b0010000,
    S_HQ    = 7'b0100000,
    S_WB    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  logic signed [kwb_pkg::COEF_W-1:0] coef_r [kwb_pkg::NUM_REGS];

  logic [kwb_pkg::CHAN_W-1:0]        chan_r;
  logic signed [kwb_pkg::SAMP_W-1:0] x_r;
  logic                              bad_r;
  logic signed [kwb_pkg::COEF_W-1:0] s_r;
  logic signed [kwb_pkg::COEF_W-1:0] y_r;

  kwb_pkg::hist_row_t mem [kwb_pkg::CHANNELS];
  logic [kwb_pkg::CHANNELS-1:0] vld_r;
  kwb_pkg::hist_row_t rd_r;
  logic               rdv_r;
  kwb_pkg::hist_row_t hist;
  kwb_pkg::hist_row_t row_new;

  logic                     out_valid_r;
  logic [kwb_pkg::CHAN_W-1:0]        out_chan_r;
  logic signed [kwb_pkg::SAMP_W-1:0] out_sample_r;

  logic in_fire, out_load, mem_we, in_range;
  logic [kwb_pkg::IDX_W-1:0] in_chan_ext, chan_ext;
  logic [kwb_pkg::CH_AW-1:0] rd_addr, wr_addr;

  kwb_pkg::mac_ctrl_t mac_ctrl;
  logic signed [kwb_pkg::COEF_W-1:0] mac_coef, mac_opnd;
  logic signed [kwb_pkg::ACC_W-1:0]  mac_ld, acc;
  logic signed [34:0]                num;

  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign in_chan_ext = kwb_pkg::IDX_W'(in_chan);
  assign chan_ext    = kwb_pkg::IDX_W'(chan_r);
  assign rd_addr     = in_chan_ext[kwb_pkg::CH_AW-1:0];
  assign wr_addr     = chan_ext[kwb_pkg::CH_AW-1:0];
  assign in_range    = ({29'b0, in_chan} < 32'(kwb_pkg::CHANNELS));
  assign out_load    = (state_r == S_WB) && (!out_valid_r || out_ready);
  assign mem_we      = out_load && !bad_r;
  assign hist        = rdv_r ? rd_r : '0;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kwb_pkg::NUM_REGS; i++) begin
        coef_r[i] <= kwb_pkg::COEF_RESET[i];
      end
    end else if (cfg_we && (cfg_idx < 3'(kwb_pkg::NUM_REGS))) begin
      coef_r[cfg_idx] <= $signed(cfg_wdata);
    end
  end

  // channel history memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= row_new;
    end
    if (in_fire) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (in_fire) begin
        rdv_r <= vld_r[rd_addr];
      end
    end
  end

  always_comb begin
    row_new.x1 = x_r;
    row_new.x2 = hist.x1;
    row_new.s1 = s_r;
    row_new.s2 = hist.s1;
    row_new.h1 = y_r;
    row_new.h2 = hist.h1;
  end

  // operand and control selection for the shared unit
  assign num = $signed({{3{s_r[31]}}, s_r})
             - $signed({{2{hist.s1[31]}}, hist.s1, 1'b0})
             + $signed({{3{hist.s2[31]}}, hist.s2});

  always_comb begin
    mac_ctrl = '0;
    mac_coef = coef_r[cnt_r < 3'(kwb_pkg::NUM_REGS) ? cnt_r : 3'(kwb_pkg::REG_SHELF_B0)];
    mac_opnd = '0;
    mac_ld   = '0;
    case (state_r)
      S_IDLE: begin
        mac_ctrl.acc_ld = 1'b1;
      end
      S_SHELF: begin
        mac_ctrl.mul_en  = (cnt_r <= 3'd4);
        mac_ctrl.acc_en  = (cnt_r >= 3'd1);
        mac_ctrl.acc_sub = (cnt_r >= 3'd4);
        case (cnt_r)
          3'd0:    mac_opnd = $signed({{2{x_r[23]}}, x_r, 6'b0});
          3'd1:    mac_opnd = $signed({{2{hist.x1[23]}}, hist.x1, 6'b0});
          3'd2:    mac_opnd = $signed({{2{hist.x2[23]}}, hist.x2, 6'b0});
          3'd3:    mac_opnd = hist.s1;
          default: mac_opnd = hist.s2;
        endcase
      end
      S_HPI: begin
        mac_ctrl.acc_ld = 1'b1;
        mac_ld          = $signed({{4{num[34]}}, num, 25'b0});
      end
      S_HP: begin
        mac_ctrl.mul_en  = (cnt_r <= 3'd1);
        mac_ctrl.acc_en  = (cnt_r >= 3'd1);
        mac_ctrl.acc_sub = 1'b1;
        mac_coef = coef_r[(cnt_r == 3'd0) ? kwb_pkg::REG_HP_A1 : kwb_pkg::REG_HP_A2];
        mac_opnd = (cnt_r == 3'd0) ? hist.h1 : hist.h2;
      end
      default: begin
      end
    endcase
  end

  kwb_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .coef   (mac_coef),
    .opnd   (mac_opnd),
    .ld_val (mac_ld),
    .acc    (acc)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) begin
          state_nxt = in_range ? S_SHELF : S_WB;
        end
      end
      S_SHELF: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          state_nxt = S_SQ;
          cnt_nxt   = '0;
        end
      end
      S_SQ:  state_nxt = S_HPI;
      S_HPI: state_nxt = S_HP;
      S_HP: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd2) begin
          state_nxt = S_HQ;
          cnt_nxt   = '0;
        end
      end
      S_HQ: state_nxt = S_WB;
      S_WB: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      chan_r <= in_chan;
      x_r    <= in_sample_in;
      bad_r  <= !in_range;
      y_r    <= '0;
    end
    if (state_r == S_SQ) begin
      s_r <= kwb_pkg::to_q6(acc);
    end
    if (state_r == S_HQ) begin
      y_r <= kwb_pkg::to_q6(acc);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r   <= chan_r;
      out_sample_r <= kwb_pkg::out_round(y_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_chan_out   = out_chan_r;
  assign out_sample_out = out_sample_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input ready while transaction in flight");

  a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_SHELF || state_r == S_WB))
    else $error("accepted transaction took no valid path");

  a_load_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WB))
    else $error("result presented outside write-back");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HP |-> cnt_r <= 3'd2)
    else $error("high-pass step count overrun");

endmodule

/* tb/k_weighting_biquad_cascade_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for k_weighting_biquad_cascade_core: directed and random samples
// under several coefficient sets, compared with a cycle-free shelf/high-pass predictor.
// Depends on kwb_pkg and the RTL of the core.
module k_weighting_biquad_cascade_core_tb;
  import kwb_pkg::*;

  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          RAND_PER_SET   = 140;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          MAX_REPORTS    = 10;
  localparam int          DIRECTED_ROWS  = 22;
  localparam logic [2:0]  REG_IDX_NONE   = 3'd7;
  localparam logic signed [SAMP_W-1:0] SAMP_MAX = 24'sh7fffff;
  localparam logic signed [SAMP_W-1:0] SAMP_MIN = 24'sh800000;

  typedef enum int {
    SET_RESET, SET_RELOAD, SET_MAX, SET_MIN, SET_ZERO, SET_PASS,
    SET_RAND_WIDE, SET_RAND_NEAR, SET_RELOAD_HOLD, SET_COUNT
  } coef_set_e;

  typedef struct {
    bit [CHAN_W-1:0]        chan;
    bit signed [SAMP_W-1:0] sample;
    bit                     known;
    bit signed [SAMP_W-1:0] result;
  } stim_row_t;

  typedef struct {
    logic [CHAN_W-1:0]        chan;
    logic signed [SAMP_W-1:0] sample;
  } kw_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [CHAN_W-1:0]        in_chan;
  logic signed [SAMP_W-1:0] in_sample_in;
  logic                     out_valid;
  logic                     out_ready;
  logic [CHAN_W-1:0]        out_chan_out;
  logic signed [SAMP_W-1:0] out_sample_out;
  logic                     cfg_we;
  logic [2:0]               cfg_idx;
  logic [COEF_W-1:0]        cfg_wdata;

  int         coef_model [NUM_REGS];
  int         x_hist [CHANNELS][2];
  int         shelf_hist [CHANNELS][2];
  int         hp_hist [CHANNELS][2];
  kw_result_t pending_results [$];

  int  cycle_count     = 0;
  int  samples_sent    = 0;
  int  results_checked = 0;
  int  mismatches      = 0;
  bit  rx_enable       = 1'b0;
  bit  rx_steady       = 1'b0;
  bit  tx_steady       = 1'b0;
  bit  hold_req        = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{3'd0, 24'sd0,       1'b1, 24'sd0},
    '{3'd7, 24'sd0,       1'b1, 24'sd0},
    '{3'd5, 24'sd0,       1'b1, 24'sd0},
    '{3'd0, SAMP_MAX,     1'b0, 24'sd0},
    '{3'd0, SAMP_MIN,     1'b0, 24'sd0},
    '{3'd0, SAMP_MAX,     1'b0, 24'sd0},
    '{3'd0, SAMP_MIN,     1'b0, 24'sd0},
    '{3'd1, SAMP_MIN,     1'b0, 24'sd0},
    '{3'd1, SAMP_MIN,     1'b0, 24'sd0},
    '{3'd1, SAMP_MIN,     1'b0, 24'sd0},
    '{3'd2, 24'sd1,       1'b0, 24'sd0},
    '{3'd2, -24'sd1,      1'b0, 24'sd0},
    '{3'd3, 24'sh555555,  1'b0, 24'sd0},
    '{3'd3, 24'shaaaaaa,  1'b0, 24'sd0},
    '{3'd4, SAMP_MAX,     1'b0, 24'sd0},
    '{3'd4, SAMP_MAX,     1'b0, 24'sd0},
    '{3'd6, 24'sh400000,  1'b0, 24'sd0},
    '{3'd7, 24'shc00000,  1'b0, 24'sd0},
    '{3'd0, 24'sd0,       1'b0, 24'sd0},
    '{3'd5, SAMP_MAX,     1'b0, 24'sd0},
    '{3'd5, SAMP_MIN,     1'b0, 24'sd0},
    '{3'd2, 24'sd0,       1'b0, 24'sd0}
  };

  k_weighting_biquad_cascade_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_chan        (in_chan),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_chan_out   (out_chan_out),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic longint q31_product(int c, int v);
    return (longint'(c) * longint'(v)) >>> 3;
  endfunction

  function automatic int round_q6(longint acc);
    longint t;
    t = (acc + 64'sd16777216) >>> 25;
    if (t > 64'sd2147483647) return 32'sh7fffffff;
    if (t < -64'sd2147483648) return 32'sh80000000;
    return int'(t);
  endfunction

  function automatic void clear_filter_model();
    for (int i = 0; i < NUM_REGS; i++) coef_model[i] = COEF_RESET[i];
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < 2; k++) begin
        x_hist[c][k]     = 0;
        shelf_hist[c][k] = 0;
        hp_hist[c][k]    = 0;
      end
    end
  endfunction

  function automatic logic signed [SAMP_W-1:0] kweight_predict(int ch, logic signed [SAMP_W-1:0] x);
    longint acc;
    int     s;
    int     y;
    longint r;
    if (ch >= CHANNELS) return '0;
    acc = q31_product(coef_model[REG_SHELF_B0], int'(x) * 64)
        + q31_product(coef_model[REG_SHELF_B1], x_hist[ch][0] * 64)
        + q31_product(coef_model[REG_SHELF_B2], x_hist[ch][1] * 64)
        - q31_product(coef_model[REG_SHELF_A1], shelf_hist[ch][0])
        - q31_product(coef_model[REG_SHELF_A2], shelf_hist[ch][1]);
    s = round_q6(acc);
    acc = (longint'(s) - 2 * longint'(shelf_hist[ch][0]) + longint'(shelf_hist[ch][1]))
          * (longint'(1) <<< 25);
    acc = acc - q31_product(coef_model[REG_HP_A1], hp_hist[ch][0])
              - q31_product(coef_model[REG_HP_A2], hp_hist[ch][1]);
    y = round_q6(acc);
    x_hist[ch][1]     = x_hist[ch][0];
    x_hist[ch][0]     = int'(x);
    shelf_hist[ch][1] = shelf_hist[ch][0];
    shelf_hist[ch][0] = s;
    hp_hist[ch][1]    = hp_hist[ch][0];
    hp_hist[ch][0]    = y;
    r = (longint'(y) + 32) >>> 6;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return SAMP_W'(r);
  endfunction

  function automatic logic signed [SAMP_W-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 4))
        0: return SAMP_MAX;
        1: return SAMP_MIN;
        2: return 24'sd0;
        3: return -24'sd1;
        default: return 24'sd1;
      endcase
    end
    if (pick < 40) return SAMP_W'(int'($urandom_range(0, 2047)) - 1024);
    return SAMP_W'($urandom);
  endfunction

  // call at a rising edge; returns at the edge that accepts the transaction
  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic signed [SAMP_W-1:0] x,
                             input bit known, input logic signed [SAMP_W-1:0] fixed_result);
    int         gap;
    bit         ok;
    kw_result_t r;
    if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_chan      <= ch;
    in_sample_in <= x;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    r.chan   = ch;
    r.sample = kweight_predict(int'(ch), x);
    if (known) r.sample = fixed_result;
    pending_results.push_back(r);
    samples_sent++;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_coefs(input int vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= reg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      coef_model[i] = vals[i];
    end
    cfg_idx   <= REG_IDX_NONE;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    kw_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: chan %0d sample %0d", out_chan_out, out_sample_out);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_chan_out !== want.chan || out_sample_out !== want.sample) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: chan exp %0d got %0d, sample exp %0d got %0d",
                     results_checked, want.chan, out_chan_out, want.sample, out_sample_out);
        end
      end
    end
  end

  initial begin
    int gap;
    bit got;
    out_ready = 1'b0;
    wait (rx_enable);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_valid;
        @(posedge clk);
      end while (!got);
    end
  end

  initial begin
    int vals [NUM_REGS];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_chan      = '0;
    in_sample_in = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    clear_filter_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rx_enable = 1'b1;

    for (int s = SET_RESET; s < SET_COUNT; s++) begin
      if (s != SET_RESET) begin
        in_valid <= 1'b0;
        drain();
        for (int i = 0; i < NUM_REGS; i++) begin
          case (coef_set_e'(s))
            SET_MAX:       vals[i] = 32'sh7fffffff;
            SET_MIN:       vals[i] = 32'sh80000000;
            SET_ZERO:      vals[i] = 0;
            SET_PASS:      vals[i] = (i == REG_SHELF_B0) ? (1 <<< 28) : 0;
            SET_RAND_WIDE: vals[i] = $urandom;
            SET_RAND_NEAR: vals[i] = COEF_RESET[i] + int'($urandom_range(0, 1 << 20)) - (1 << 19);
            default:       vals[i] = COEF_RESET[i];
          endcase
        end
        load_coefs(vals);
        if (s == SET_RELOAD_HOLD) hold_req = 1'b1;
      end else begin
        foreach (directed_rows[r])
          send_sample(directed_rows[r].chan, directed_rows[r].sample,
                      directed_rows[r].known, directed_rows[r].result);
      end
      for (int n = 0; n < RAND_PER_SET; n++)
        send_sample(CHAN_W'($urandom_range(0, CHANNELS - 1)), rand_sample(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    drain();

    $display("covered %0d samples over %0d coefficient sets, %0d results checked",
             samples_sent, SET_COUNT, results_checked);
    $display("receiver held off %0d cycles once; %0d mismatches", HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/kwb_pkg.sv
hw/rtl/kwb_mac.sv
hw/rtl/k_weighting_biquad_cascade_core.sv
tb/k_weighting_biquad_cascade_core_tb.sv
